// ----- design/gac_pkg.sv -----
`timescale 1ns / 1ps

package gac_pkg;

    // request codes
    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_CHAIN_FULL = 2'd1;
    localparam logic [1:0] ST_NO_SPACE   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CELLS_PER_ROW  = 2'd0;
    localparam logic [1:0] REG_ROWS_PER_LAYER = 2'd1;
    localparam logic [1:0] REG_LAYER_LIMIT    = 2'd2;

    localparam logic [15:0] CELLS_PER_ROW_RST  = 16'd1;
    localparam logic [15:0] ROWS_PER_LAYER_RST = 16'd100;
    localparam logic [15:0] LAYER_LIMIT_RST    = 16'd1000;

    localparam int CH_W    = 21;
    localparam int COMB_W  = 32;
    localparam int KEY_W   = 54;
    localparam int SLOT_W  = 48;
    localparam int ENTRY_W = KEY_W + SLOT_W;
    localparam int HASH_W  = 10;
    localparam int NB_CMP_W = 13;

    // which result the datapath forms this cycle
    typedef enum logic [2:0] {
        RES_NONE,
        RES_HIT,
        RES_FULL,
        RES_INSERT,
        RES_RESERVE,
        RES_ZERO
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     fill_latch;
        logic     idx_clr;
        logic     idx_inc;
        logic     clr_start;
        logic     clr_step;
        res_sel_t res_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_at_fill;
        logic       chain_full;
        logic       key_match;
        logic       clr_last;
    } dp_stat_t;

endpackage

// ----- design/gac_ram.sv -----
`timescale 1ns / 1ps

module gac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/gac_ctrl.sv -----
`timescale 1ns / 1ps

module gac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gac_pkg::dp_cmd_t  cmd,
    input  gac_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_FILL,
        S_RD,
        S_CMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   clr_rsp_reg;
    logic   clr_rsp_next;

    always_comb
    begin
        cmd          = '0;
        cmd.res_sel  = gac_pkg::RES_NONE;
        state_next   = state_reg;
        clr_rsp_next = clr_rsp_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next   = clr_rsp_reg ? S_DONE : S_IDLE;
                    clr_rsp_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                case (stat.op)
                    gac_pkg::OP_LOOKUP:
                    begin
                        // fill read of the bucket is in flight
                        state_next = S_FILL;
                    end
                    gac_pkg::OP_RESERVE:
                    begin
                        cmd.res_sel = gac_pkg::RES_RESERVE;
                        state_next  = S_DONE;
                    end
                    gac_pkg::OP_CLEAR:
                    begin
                        cmd.clr_start = 1'b1;
                        cmd.res_sel   = gac_pkg::RES_ZERO;
                        clr_rsp_next  = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    default:
                    begin
                        cmd.res_sel = gac_pkg::RES_ZERO;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_FILL:
            begin
                cmd.fill_latch = 1'b1;
                cmd.idx_clr    = 1'b1;
                state_next     = S_RD;
            end
            S_RD:
            begin
                if (stat.idx_at_fill)
                begin
                    cmd.res_sel = stat.chain_full ? gac_pkg::RES_FULL : gac_pkg::RES_INSERT;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.key_match)
                begin
                    cmd.res_sel = gac_pkg::RES_HIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            clr_rsp_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_rsp_reg   <= clr_rsp_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- design/gac_dp.sv -----
`timescale 1ns / 1ps

module gac_dp #(
    parameter int NUM_BUCKETS = 1024,
    parameter int CHAIN_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [1:0]        op,
    input  logic [20:0]       ch,
    input  logic [31:0]       combining,
    input  logic              second_half,
    input  logic [1:0]        style_bits,
    input  gac_pkg::dp_cmd_t  cmd,
    output gac_pkg::dp_stat_t stat,
    output logic [15:0]       glyph_col,
    output logic [15:0]       glyph_row,
    output logic [15:0]       glyph_layer,
    output logic              hit,
    output logic [1:0]        status,
    output logic [15:0]       rows_in_use
);

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int FW = $clog2(CHAIN_DEPTH + 1);
    localparam int ENTRIES = NUM_BUCKETS * CHAIN_DEPTH;
    localparam int AW = $clog2(ENTRIES);
    localparam logic [gac_pkg::NB_CMP_W-1:0] NB_CMP = gac_pkg::NB_CMP_W'(NUM_BUCKETS);
    localparam logic [FW-1:0] DEPTH_F = FW'(CHAIN_DEPTH);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);

    // configuration
    logic [15:0] cells_per_row_reg;
    logic [15:0] rows_per_layer_reg;
    logic [15:0] layer_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_per_row_reg  <= gac_pkg::CELLS_PER_ROW_RST;
            rows_per_layer_reg <= gac_pkg::ROWS_PER_LAYER_RST;
            layer_limit_reg    <= gac_pkg::LAYER_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                gac_pkg::REG_CELLS_PER_ROW:  cells_per_row_reg  <= cfg_data;
                gac_pkg::REG_ROWS_PER_LAYER: rows_per_layer_reg <= cfg_data;
                gac_pkg::REG_LAYER_LIMIT:    layer_limit_reg    <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // bucket hash, reduced modulo the bucket count
    logic [gac_pkg::NB_CMP_W-1:0] hash_mod;
    always_comb
    begin
        hash_mod = gac_pkg::NB_CMP_W'({style_bits, ch[7:0]});
        for (int k = 0; k < 4; k++)
        begin
            if (hash_mod >= NB_CMP)
            begin
                hash_mod = hash_mod - NB_CMP;
            end
        end
    end

    // captured request
    logic [1:0]                op_reg;
    logic [gac_pkg::KEY_W-1:0] key_reg;
    logic [BW-1:0]             bucket_reg;
    logic [AW-1:0]             base_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            key_reg    <= {second_half, combining, ch};
            bucket_reg <= hash_mod[BW-1:0];
        end
        base_reg <= AW'(bucket_reg * CHAIN_DEPTH);
    end

    // chain scan
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] idx_reg;
    logic [FW-1:0] fill_rdata;
    logic [gac_pkg::ENTRY_W-1:0] entry_rdata;
    logic [gac_pkg::SLOT_W-1:0]  hit_slot;

    always_ff @(posedge clk)
    begin
        if (cmd.fill_latch)
        begin
            fill_reg <= (fill_rdata > DEPTH_F) ? DEPTH_F : fill_rdata;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign hit_slot = entry_rdata[gac_pkg::ENTRY_W-1:gac_pkg::KEY_W];

    // clearing sweep over the fill table
    logic [BW-1:0] clr_cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // memories
    logic          ins_we;
    logic          fill_we;
    logic [BW-1:0] fill_waddr;
    logic [FW-1:0] fill_wdata;

    assign ins_we     = (cmd.res_sel == gac_pkg::RES_INSERT);
    assign fill_we    = ins_we || cmd.clr_step;
    assign fill_waddr = cmd.clr_step ? clr_cnt_reg : bucket_reg;
    assign fill_wdata = cmd.clr_step ? '0 : fill_reg + 1'b1;

    logic [15:0] col_reg;
    logic [15:0] row_reg;
    logic [15:0] layer_reg;
    logic [15:0] hm_reg;

    gac_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (bucket_reg),
        .rdata (fill_rdata)
    );

    gac_ram #(
        .WIDTH (gac_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ins_we),
        .waddr (base_reg + AW'(fill_reg)),
        .wdata ({layer_reg, row_reg, col_reg, key_reg}),
        .raddr (base_reg + AW'(idx_reg)),
        .rdata (entry_rdata)
    );

    // slot cursor step
    logic [15:0] cols;
    logic [15:0] rows;
    logic [15:0] lim;
    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic [16:0] layer_inc;
    logic [17:0] row_mark;
    logic [17:0] hm_max;
    logic [15:0] hm_new;
    logic        wrap_col;
    logic        wrap_row;
    logic        no_space;

    always_comb
    begin
        cols      = (cells_per_row_reg == '0) ? 16'd1 : cells_per_row_reg;
        rows      = (rows_per_layer_reg == '0) ? 16'd1 : rows_per_layer_reg;
        lim       = (layer_limit_reg == '0) ? 16'd1 : layer_limit_reg;
        col_inc   = {1'b0, col_reg} + 17'd1;
        row_inc   = {1'b0, row_reg} + 17'd1;
        layer_inc = {1'b0, layer_reg} + 17'd1;
        row_mark  = {2'b00, row_reg} + 18'd2;
        wrap_col  = col_inc >= {1'b0, cols};
        wrap_row  = row_inc >= {1'b0, rows};
        hm_max    = (row_mark > {2'b00, hm_reg}) ? row_mark : {2'b00, hm_reg};
        hm_new    = (hm_max > {2'b00, rows}) ? rows : hm_max[15:0];
        no_space  = wrap_col && wrap_row && (layer_inc >= {1'b0, lim});
    end

    logic advance;
    assign advance = ins_we || (cmd.res_sel == gac_pkg::RES_RESERVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            layer_reg <= '0;
            hm_reg    <= 16'd1;
        end
        else if (cmd.clr_start)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            layer_reg <= '0;
            hm_reg    <= 16'd1;
        end
        else if (advance)
        begin
            if (wrap_col)
            begin
                col_reg <= '0;
                hm_reg  <= hm_new;
                if (wrap_row)
                begin
                    row_reg   <= '0;
                    layer_reg <= layer_inc[15:0];
                end
                else
                begin
                    row_reg <= row_inc[15:0];
                end
            end
            else
            begin
                col_reg <= col_inc[15:0];
            end
        end
    end

    // result staging and output register
    logic [15:0] res_col_reg;
    logic [15:0] res_row_reg;
    logic [15:0] res_layer_reg;
    logic        res_hit_reg;
    logic [1:0]  res_status_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.res_sel)
            gac_pkg::RES_HIT:
            begin
                res_col_reg    <= hit_slot[15:0];
                res_row_reg    <= hit_slot[31:16];
                res_layer_reg  <= hit_slot[47:32];
                res_hit_reg    <= 1'b1;
                res_status_reg <= gac_pkg::ST_OK;
            end
            gac_pkg::RES_FULL:
            begin
                res_col_reg    <= '0;
                res_row_reg    <= '0;
                res_layer_reg  <= '0;
                res_hit_reg    <= 1'b0;
                res_status_reg <= gac_pkg::ST_CHAIN_FULL;
            end
            gac_pkg::RES_INSERT, gac_pkg::RES_RESERVE:
            begin
                res_col_reg    <= col_reg;
                res_row_reg    <= row_reg;
                res_layer_reg  <= layer_reg;
                res_hit_reg    <= 1'b0;
                res_status_reg <= no_space ? gac_pkg::ST_NO_SPACE : gac_pkg::ST_OK;
            end
            gac_pkg::RES_ZERO:
            begin
                res_col_reg    <= '0;
                res_row_reg    <= '0;
                res_layer_reg  <= '0;
                res_hit_reg    <= 1'b0;
                res_status_reg <= gac_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            glyph_col   <= res_col_reg;
            glyph_row   <= res_row_reg;
            glyph_layer <= res_layer_reg;
            hit         <= res_hit_reg;
            status      <= res_status_reg;
            rows_in_use <= hm_reg;
        end
    end

    always_comb
    begin
        stat.op          = op_reg;
        stat.idx_at_fill = idx_reg >= fill_reg;
        stat.chain_full  = fill_reg >= DEPTH_F;
        stat.key_match   = entry_rdata[gac_pkg::KEY_W-1:0] == key_reg;
        stat.clr_last    = clr_cnt_reg == LAST_BUCKET;
    end

endmodule

// ----- design/glyph_atlas_slot_cache_core.sv -----
`timescale 1ns / 1ps

// glyph atlas slot cache: maps a glyph key (code point, packed combining marks,
// second-half flag) to a column/row/layer slot of a texture atlas. the bucket
// is the low code point byte with the two style bits, modulo NUM_BUCKETS, and
// each bucket chains up to CHAIN_DEPTH keys in an entry memory. one request is
// in flight at a time; the finished result sits in an output register, so a
// new transaction is taken while the previous result waits. the chain is read
// one entry at a time through the registered entry memory port, each entry
// passing the read and compare states. a result that finds the output register
// still full waits until the register drains. clear, and also reset, sweep the
// bucket fill memory one bucket per cycle with the input ready low;
// configuration writes are taken at any time and should only be issued while
// the block is idle
module glyph_atlas_slot_cache_core #(
    parameter int NUM_BUCKETS = 1024,
    parameter int CHAIN_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [20:0] ch,
    input  logic [31:0] combining,
    input  logic        second_half,
    input  logic [1:0]  style_bits,

    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] glyph_col,
    output logic [15:0] glyph_row,
    output logic [15:0] glyph_layer,
    output logic        hit,
    output logic [1:0]  status,
    output logic [15:0] rows_in_use
);

    gac_pkg::dp_cmd_t  cmd;
    gac_pkg::dp_stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencing: dispatch on op, chain walk, result hand-off
    gac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // memories, slot cursor, key compare and result registers
    gac_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .CHAIN_DEPTH (CHAIN_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .ch          (ch),
        .combining   (combining),
        .second_half (second_half),
        .style_bits  (style_bits),
        .cmd         (cmd),
        .stat        (stat),
        .glyph_col   (glyph_col),
        .glyph_row   (glyph_row),
        .glyph_layer (glyph_layer),
        .hit         (hit),
        .status      (status),
        .rows_in_use (rows_in_use)
    );

endmodule

// ----- tb/glyph_atlas_slot_cache_core_test.sv -----
`timescale 1ns / 1ps

module glyph_atlas_slot_cache_core_test;

    localparam int NUM_BUCKETS = 1024;
    localparam int CHAIN_DEPTH = 4;
    localparam int ENTRIES     = NUM_BUCKETS * CHAIN_DEPTH;
    localparam int POOL_SIZE   = 48;
    localparam int HOT_COUNT   = 6;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 180;

    // one request transaction
    typedef struct packed {
        logic [1:0]  op;
        logic [20:0] ch;
        logic [31:0] combining;
        logic        second_half;
        logic [1:0]  style_bits;
    } glyph_req_t;

    // one result transaction
    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [15:0] layer;
        logic        hit;
        logic [1:0]  status;
        logic [15:0] rows_in_use;
    } slot_res_t;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the table, cursor and registers; every
    // accepted request is turned into the slot result it must produce
    // ------------------------------------------------------------------
    class slot_scoreboard;
        logic [15:0] cells_per_row;
        logic [15:0] rows_per_layer;
        logic [15:0] layer_limit;
        logic [2:0]  fill_count [NUM_BUCKETS];
        logic [53:0] key_store  [ENTRIES];
        logic [47:0] slot_store [ENTRIES];
        logic [15:0] cur_col;
        logic [15:0] cur_row;
        logic [15:0] cur_layer;
        logic [15:0] row_mark;
        slot_res_t   expected_slots [$];
        int          errors;

        function new();
            cells_per_row  = gac_pkg::CELLS_PER_ROW_RST;
            rows_per_layer = gac_pkg::ROWS_PER_LAYER_RST;
            layer_limit    = gac_pkg::LAYER_LIMIT_RST;
            errors         = 0;
            clear_table();
        endfunction

        function void clear_table();
            foreach (fill_count[b])
                fill_count[b] = 3'd0;
            cur_col   = 16'd0;
            cur_row   = 16'd0;
            cur_layer = 16'd0;
            row_mark  = 16'd1;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                gac_pkg::REG_CELLS_PER_ROW:  cells_per_row  = value;
                gac_pkg::REG_ROWS_PER_LAYER: rows_per_layer = value;
                gac_pkg::REG_LAYER_LIMIT:    layer_limit    = value;
                default: ;
            endcase
        endfunction

        // step the cursor one slot: columns, then rows, then layers
        function logic [1:0] advance_cursor();
            int unsigned cols;
            int unsigned rows;
            int unsigned lim;
            int unsigned c;
            int unsigned r;
            int unsigned z;
            int unsigned hm;
            logic [1:0]  st;
            // a zero register behaves as one
            cols = (cells_per_row == 16'd0) ? 1 : cells_per_row;
            rows = (rows_per_layer == 16'd0) ? 1 : rows_per_layer;
            lim  = (layer_limit == 16'd0) ? 1 : layer_limit;
            st   = gac_pkg::ST_OK;
            c    = cur_col + 1;
            // >= so that a cursor beyond a shrunk register wraps at once
            if (c >= cols) begin
                c  = 0;
                r  = cur_row + 1;
                hm = row_mark;
                if (r + 1 > hm)
                    hm = r + 1;
                if (hm > rows)
                    hm = rows;
                row_mark = hm[15:0];
                if (r >= rows) begin
                    r = 0;
                    z = cur_layer + 1;
                    if (z >= lim)
                        st = gac_pkg::ST_NO_SPACE;
                    // layer 65536 wraps to zero
                    cur_layer = z[15:0];
                end
                cur_row = r[15:0];
            end
            cur_col = c[15:0];
            return st;
        endfunction

        function slot_res_t predict_slot(glyph_req_t r);
            slot_res_t   res;
            int unsigned bkt;
            int unsigned base;
            int unsigned fill;
            logic [53:0] key;
            logic [47:0] slot;
            bit          found;
            res        = '0;
            res.status = gac_pkg::ST_OK;
            case (r.op)
                gac_pkg::OP_CLEAR: clear_table();
                gac_pkg::OP_RESERVE: begin
                    res.col    = cur_col;
                    res.row    = cur_row;
                    res.layer  = cur_layer;
                    res.status = advance_cursor();
                end
                gac_pkg::OP_LOOKUP: begin
                    bkt   = {r.style_bits, r.ch[7:0]} % NUM_BUCKETS;
                    base  = bkt * CHAIN_DEPTH;
                    fill  = fill_count[bkt];
                    key   = {r.second_half, r.combining, r.ch};
                    found = 1'b0;
                    slot  = '0;
                    for (int i = 0; i < fill; i++) begin
                        if (!found && key_store[base + i] == key) begin
                            found = 1'b1;
                            slot  = slot_store[base + i];
                        end
                    end
                    if (found) begin
                        res.col   = slot[15:0];
                        res.row   = slot[31:16];
                        res.layer = slot[47:32];
                        res.hit   = 1'b1;
                    end else if (fill >= CHAIN_DEPTH) begin
                        // chain full: nothing stored, nothing advanced
                        res.status = gac_pkg::ST_CHAIN_FULL;
                    end else begin
                        res.col   = cur_col;
                        res.row   = cur_row;
                        res.layer = cur_layer;
                        key_store[base + fill]  = key;
                        slot_store[base + fill] = {cur_layer, cur_row, cur_col};
                        fill_count[bkt]         = fill_count[bkt] + 3'd1;
                        res.status              = advance_cursor();
                    end
                end
                default: ;
            endcase
            res.rows_in_use = row_mark;
            return res;
        endfunction

        function void take_request(glyph_req_t r);
            expected_slots.push_back(predict_slot(r));
        endfunction

        function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void compare_result(slot_res_t act);
            slot_res_t exp_r;
            if (expected_slots.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual col %0d row %0d",
                         $time, act.col, act.row);
                errors++;
                return;
            end
            exp_r = expected_slots.pop_front();
            check_field("glyph_col", exp_r.col, act.col);
            check_field("glyph_row", exp_r.row, act.row);
            check_field("glyph_layer", exp_r.layer, act.layer);
            check_field("hit", 16'(exp_r.hit), 16'(act.hit));
            check_field("status", 16'(exp_r.status), 16'(act.status));
            check_field("rows_in_use", exp_r.rows_in_use, act.rows_in_use);
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;

    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = gac_pkg::REG_CELLS_PER_ROW;
    logic [15:0] cfg_data    = 16'd0;

    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  op          = gac_pkg::OP_LOOKUP;
    logic [20:0] ch          = 21'd0;
    logic [31:0] combining   = 32'd0;
    logic        second_half = 1'b0;
    logic [1:0]  style_bits  = 2'd0;

    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [15:0] glyph_col;
    logic [15:0] glyph_row;
    logic [15:0] glyph_layer;
    logic        hit;
    logic [1:0]  status;
    logic [15:0] rows_in_use;

    // idle bursts on each side, switched per phase
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    int          rx_stall_left = 0;

    // keys that share a few buckets, so chains fill up and hits are common
    glyph_req_t  key_pool   [POOL_SIZE];
    logic [9:0]  hot_bucket [HOT_COUNT];

    slot_scoreboard sb;

    always #6 clk = ~clk;

    glyph_atlas_slot_cache_core #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .CHAIN_DEPTH (CHAIN_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .ch          (ch),
        .combining   (combining),
        .second_half (second_half),
        .style_bits  (style_bits),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .glyph_col   (glyph_col),
        .glyph_row   (glyph_row),
        .glyph_layer (glyph_layer),
        .hit         (hit),
        .status      (status),
        .rows_in_use (rows_in_use)
    );

    // ------------------------------------------------------------------
    // monitors: all sample pre-edge values at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.set_register(cfg_index, cfg_data);
    end

    always @(posedge clk)
    begin
        glyph_req_t req;
        if (rst_n && in_valid && in_ready) begin
            req.op          = op;
            req.ch          = ch;
            req.combining   = combining;
            req.second_half = second_half;
            req.style_bits  = style_bits;
            sb.take_request(req);
        end
    end

    always @(posedge clk)
    begin
        slot_res_t res;
        if (rst_n && out_valid && out_ready) begin
            res.col         = glyph_col;
            res.row         = glyph_row;
            res.layer       = glyph_layer;
            res.hit         = hit;
            res.status      = status;
            res.rows_in_use = rows_in_use;
            sb.compare_result(res);
        end
    end

    // result side back-pressure: random stall bursts that hold out_ready low
    always @(posedge clk)
    begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            out_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(1, 18) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic glyph_req_t make_req(logic [1:0] o, logic [20:0] c,
                                            logic [31:0] comb, logic sec,
                                            logic [1:0] sty);
        glyph_req_t r;
        r.op          = o;
        r.ch          = c;
        r.combining   = comb;
        r.second_half = sec;
        r.style_bits  = sty;
        return r;
    endfunction

    // new key landing in one of the hot buckets
    function automatic glyph_req_t hot_key();
        glyph_req_t r;
        logic [9:0] b;
        b             = hot_bucket[$urandom_range(0, HOT_COUNT - 1)];
        r.op          = gac_pkg::OP_LOOKUP;
        r.style_bits  = b[9:8];
        r.ch          = {13'($urandom_range(0, 'h10FF)), b[7:0]};
        r.combining   = $urandom_range(0, 1) ? 32'($urandom) : 32'd0;
        r.second_half = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic glyph_req_t random_request();
        glyph_req_t r;
        int         pick;
        int         k;
        int         flip_pos;
        pick          = $urandom_range(0, 99);
        k             = $urandom_range(0, POOL_SIZE - 1);
        r.op          = gac_pkg::OP_LOOKUP;
        r.ch          = 21'($urandom_range(0, 1114111));
        r.combining   = $urandom;
        r.second_half = 1'($urandom_range(0, 1));
        r.style_bits  = 2'($urandom_range(0, 3));
        if (pick < 2) begin
            r.op = gac_pkg::OP_CLEAR;
        end else if (pick < 4) begin
            r.op = gac_pkg::OP_UNUSED;
        end else if (pick < 16) begin
            r.op = gac_pkg::OP_RESERVE;
        end else if (pick < 61) begin
            // repeat of a known key, mostly a hit
            if ($urandom_range(0, 19) == 0)
                key_pool[k] = hot_key();
            r = key_pool[k];
        end else if (pick < 76) begin
            // near miss: same bucket, one key field differs
            r = key_pool[k];
            case ($urandom_range(0, 2))
                0: r.second_half = ~r.second_half;
                1: begin
                    flip_pos              = $urandom_range(0, 31);
                    r.combining[flip_pos] = ~r.combining[flip_pos];
                end
                default: begin
                    flip_pos       = $urandom_range(8, 15);
                    r.ch[flip_pos] = ~r.ch[flip_pos];
                end
            endcase
        end else if (pick < 88) begin
            r = hot_key();
        end
        return r;
    endfunction

    // drive one request and hold it until the block takes it
    task automatic send_request(input glyph_req_t r);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= r.op;
        ch          <= r.ch;
        combining   <= r.combining;
        second_half <= r.second_half;
        style_bits  <= r.style_bits;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop sending and let every outstanding result drain
    task automatic pause_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic program_regs(input logic [15:0] cells, input logic [15:0] rows,
                                input logic [15:0] limit);
        write_reg(gac_pkg::REG_CELLS_PER_ROW, cells);
        write_reg(gac_pkg::REG_ROWS_PER_LAYER, rows);
        write_reg(gac_pkg::REG_LAYER_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        foreach (hot_bucket[i])
            hot_bucket[i] = 10'($urandom_range(0, NUM_BUCKETS - 1));
        foreach (key_pool[i])
            key_pool[i] = hot_key();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part under the reset register values
        // first insert and its hit, bucket zero
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'd0, 32'd0, 1'b0, 2'd0));
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'd0, 32'd0, 1'b0, 2'd0));
        // highest code point with all-ones combining and second half, in the last bucket
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'h10FFFF, 32'hFFFF_FFFF, 1'b1, 2'd3));
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'h10FFFF, 32'hFFFF_FFFF, 1'b1, 2'd3));
        // same bucket, keys differing only in second half, combining, high code point
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'd0, 32'd0, 1'b1, 2'd0));
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'd0, 32'd1, 1'b0, 2'd0));
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'h100, 32'd0, 1'b0, 2'd0));
        // fifth key into a full chain
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'h200, 32'd0, 1'b0, 2'd0));
        // stored keys still hit in a full chain
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'h100, 32'd0, 1'b0, 2'd0));
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'd0, 32'd0, 1'b1, 2'd0));
        // style bits pick another bucket for the same key
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'd0, 32'd0, 1'b0, 2'd1));
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'd0, 32'd0, 1'b0, 2'd2));
        send_request(make_req(gac_pkg::OP_RESERVE, 21'h1FFFFF, 32'hFFFF_FFFF, 1'b1, 2'd3));
        send_request(make_req(gac_pkg::OP_RESERVE, 21'd0, 32'd0, 1'b0, 2'd0));
        send_request(make_req(gac_pkg::OP_UNUSED, 21'h0ABCDE, 32'h1234_5678, 1'b1, 2'd2));
        send_request(make_req(gac_pkg::OP_CLEAR, 21'h10FFFF, 32'hFFFF_FFFF, 1'b1, 2'd3));
        // table is empty again: both keys miss from slot zero
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'd0, 32'd0, 1'b0, 2'd0));
        send_request(make_req(gac_pkg::OP_LOOKUP, 21'h10FFFF, 32'hFFFF_FFFF, 1'b1, 2'd3));
        send_request(make_req(gac_pkg::OP_UNUSED, 21'd0, 32'd0, 1'b0, 2'd0));

        for (int p = 0; p < PHASES; p++) begin
            pause_requests();
            case (p)
                0: program_regs(16'd65535, 16'd65535, 16'd65535);
                // cursor column sits beyond the new row width
                1: program_regs(16'd3, 16'd2, 16'd2);
                // zero registers act as one
                2: program_regs(16'd0, 16'd0, 16'd0);
                3: program_regs(16'd1, 16'd1, 16'd1);
                4: program_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                                16'($urandom_range(1, 6)));
                default: program_regs(16'($urandom_range(1, 5)), 16'($urandom_range(1, 4)),
                                      16'($urandom_range(1, 65535)));
            endcase
            // vary which side idles; the final phase runs with no idling
            tx_idle_en = (p < PHASES - 1) && (p % 3 != 1);
            rx_idle_en = (p < PHASES - 1) && (p % 3 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0)
                    pause_requests();
                send_request(random_request());
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit, several times the slowest legal run
    initial
    begin
        #(40_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
